FILE: rtl/closest_match_keep_duplicates_core_assert.svh
// Assertion macros for the closest-match core
`ifndef CLOSEST_MATCH_KEEP_DUPLICATES_CORE_ASSERT_SVH
`define CLOSEST_MATCH_KEEP_DUPLICATES_CORE_ASSERT_SVH
`ifndef SYNTH
`define CMKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmkd assertion failed");
`define CMKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmkd assertion failed");
`else
`define CMKD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CMKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/cmkd_pkg.sv
// Types and constants shared by the closest-match core
`default_nettype none
package cmkd_pkg;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_NO_MATCH     = 1'b0;
    localparam logic CFG_TABLE_LENGTH = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  entry_index;
        logic [31:0] sample_value;
        logic [31:0] tolerance;
    } req_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               matched;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LEFT,
        ST_DECIDE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/closest_match_keep_duplicates_core.sv
// Top level of the sorted-table closest-match core
//
// Loads a sorted table one entry per write request and answers increasing
// query requests with the 1-based index of the nearest entry within the
// request's tolerance (left neighbor wins ties), or the no-match value. A
// write request is taken while idle and busy stays low. A query request
// walks the search pointer one table entry at a time through the single
// read port of the table RAM, then reads the left neighbor and decides;
// busy is high from the walk to the decision. The result shows for one
// cycle with done, in the first cycle that busy is low, and the next request
// can already be accepted in that cycle. There is no backpressure: the
// receiver must take the result in that cycle. The table needs no clearing
// pass; entries are valid once written.
`default_nettype none
module closest_match_keep_duplicates_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire cmkd_pkg::req_t request,
    output logic                busy,
    output logic                done,
    output cmkd_pkg::result_t   result,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [31:0]    cfg_data
);

    localparam int PW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

    logic [31:0]   no_match_reg;
    logic [10:0]   length_reg;
    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_match_reg <= 32'h8000_0000;
            length_reg   <= 11'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cmkd_pkg::CFG_NO_MATCH:     no_match_reg <= cfg_data;
                cmkd_pkg::CFG_TABLE_LENGTH: length_reg   <= cfg_data[10:0];
                default:                    no_match_reg <= no_match_reg;
            endcase
        end
    end

    cmkd_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PW          (PW)
    ) u_search (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .request        (request),
        .busy           (busy),
        .done           (done),
        .result         (result),
        .no_match_value (no_match_reg),
        .table_length   (length_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    cmkd_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (PW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/cmkd_table_ram.sv
// Table RAM: one write port, one read port with registered read data
`default_nettype none
module cmkd_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/cmkd_search.sv
// Search sequencer: pointer walk over the table RAM and match decision
`default_nettype none
`include "closest_match_keep_duplicates_core_assert.svh"
module cmkd_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PW          = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cmkd_pkg::req_t    request,
    output logic                   busy,
    output logic                   done,
    output cmkd_pkg::result_t      result,
    input  wire logic [31:0]       no_match_value,
    input  wire logic [10:0]       table_length,
    output logic                   ram_we,
    output logic [PW-1:0]          ram_waddr,
    output logic [31:0]            ram_wdata,
    output logic [PW-1:0]          ram_raddr,
    input  wire logic [31:0]       ram_rdata
);

    cmkd_pkg::state_t  state_reg, state_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [31:0]       val_reg, val_next;
    logic [31:0]       tol_reg, tol_next;
    logic [31:0]       right_reg, right_next;
    logic [31:0]       left_reg, left_next;
    logic              done_reg, done_next;
    cmkd_pkg::result_t result_reg, result_next;

    logic [31:0]       len32, len_c, idx32;
    logic [PW-1:0]     last, ptr_start;
    logic              accept, is_query, adv, in_range;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        len32 = 32'(table_length);
        if (len32 < 32'd2)
        begin
            len_c = 32'd2;
        end
        else if (len32 > 32'(TABLE_DEPTH))
        begin
            len_c = 32'(TABLE_DEPTH);
        end
        else
        begin
            len_c = len32;
        end
        last = PW'(len_c - 32'd1);
    end

    assign busy      = (state_reg != cmkd_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign is_query  = (request.req_type == cmkd_pkg::REQ_QUERY);
    assign ptr_start = (ptr_reg > last) ? last : ptr_reg;
    assign adv       = (ptr_reg < last) && (ram_rdata < val_reg);
    assign idx32     = 32'(request.entry_index);
    assign in_range  = (idx32 < 32'(TABLE_DEPTH));
    assign ram_waddr = idx32[PW-1:0];
    assign ram_wdata = request.sample_value;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmkd_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = cmkd_pkg::ST_WALK;
                end
            end
            cmkd_pkg::ST_WALK:
            begin
                if (!adv)
                begin
                    state_next = cmkd_pkg::ST_LEFT;
                end
            end
            cmkd_pkg::ST_LEFT:
            begin
                state_next = cmkd_pkg::ST_DECIDE;
            end
            cmkd_pkg::ST_DECIDE:
            begin
                state_next = cmkd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cmkd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        val_next    = val_reg;
        tol_next    = tol_reg;
        right_next  = right_reg;
        left_next   = left_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_raddr   = ptr_reg;
        case (state_reg)
            cmkd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_query)
                    begin
                        ptr_next  = ptr_start;
                        val_next  = request.sample_value;
                        tol_next  = request.tolerance;
                        ram_raddr = ptr_start;
                    end
                    else
                    begin
                        ram_we   = in_range;
                        ptr_next = PW'(1);
                    end
                end
            end
            cmkd_pkg::ST_WALK:
            begin
                // read data is table[ptr]; fetch the next entry or the left neighbor
                if (adv)
                begin
                    ptr_next  = ptr_reg + PW'(1);
                    ram_raddr = ptr_reg + PW'(1);
                end
                else
                begin
                    right_next = abs_diff(ram_rdata, val_reg);
                    ram_raddr  = ptr_reg - PW'(1);
                end
            end
            cmkd_pkg::ST_LEFT:
            begin
                left_next = abs_diff(val_reg, ram_rdata);
            end
            cmkd_pkg::ST_DECIDE:
            begin
                done_next = 1'b1;
                if ((left_reg <= tol_reg) || (right_reg <= tol_reg))
                begin
                    result_next.matched = 1'b1;
                    if (left_reg <= right_reg)
                    begin
                        result_next.position = $signed(32'(ptr_reg));
                    end
                    else
                    begin
                        result_next.position = $signed(32'(ptr_reg) + 32'd1);
                        if (ptr_reg < last)
                        begin
                            ptr_next = ptr_reg + PW'(1);
                        end
                    end
                end
                else
                begin
                    result_next.matched  = 1'b0;
                    result_next.position = $signed(no_match_value);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmkd_pkg::ST_IDLE;
            ptr_reg   <= PW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        tol_reg    <= tol_next;
        right_reg  <= right_next;
        left_reg   <= left_next;
        result_reg <= result_next;
    end

    `CMKD_ASSERT_IMPL(a_ptr_nonzero, clk, rst_n, 1'b1, ptr_reg != '0)
    `CMKD_ASSERT_IMPL(a_done_after_decide, clk, rst_n, done_reg, $past(state_reg == cmkd_pkg::ST_DECIDE))
    `CMKD_ASSERT_NEXT(a_write_rewinds, clk, rst_n, accept && !is_query, ptr_reg == PW'(1))
    `CMKD_ASSERT_NEXT(a_idle_holds, clk, rst_n, !busy && !(start && is_query), !busy)

endmodule
`default_nettype wire

FILE: sim/cmkd_match_monitor.sv
// Checker for the closest-match core: mirrors table, pointer and registers, compares each result
module cmkd_match_monitor #(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmkd_pkg::req_t    request,
    input  logic              busy,
    input  logic              done,
    input  cmkd_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    output int                mismatches,
    output int                pending
);

    logic [31:0]       entries [DEPTH];
    logic [10:0]       cursor;
    logic [31:0]       miss_code;
    logic [10:0]       length_reg;
    cmkd_pkg::result_t expected_matches [$];
    cmkd_pkg::result_t want;
    int                fail_count = 0;
    int                waiting = 0;

    assign mismatches = fail_count;
    assign pending    = waiting;

    task automatic predict_lookup(input logic [31:0] probe, input logic [31:0] tol);
        logic [10:0]       last;
        logic [10:0]       p;
        logic [31:0]       dist_left;
        logic [31:0]       dist_right;
        cmkd_pkg::result_t r;
        if (length_reg < 11'd2)
            last = 11'd1;
        else if (length_reg > 11'(DEPTH))
            last = 11'(DEPTH - 1);
        else
            last = length_reg - 11'd1;
        p = cursor;
        if (p < 11'd1)
            p = 11'd1;
        if (p > last)
            p = last;
        while (p < last && entries[p] < probe)
            p = p + 11'd1;
        dist_left  = (probe >= entries[p - 11'd1]) ? probe - entries[p - 11'd1]
                                                   : entries[p - 11'd1] - probe;
        dist_right = (probe >= entries[p]) ? probe - entries[p] : entries[p] - probe;
        if (dist_left <= tol || dist_right <= tol)
        begin
            if (dist_left <= dist_right)
                r.position = {21'd0, p};
            else
            begin
                r.position = {21'd0, p + 11'd1};
                if (p < last)
                    p = p + 11'd1;
            end
            r.matched = 1'b1;
        end
        else
        begin
            r.position = miss_code;
            r.matched  = 1'b0;
        end
        cursor = p;
        expected_matches.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor     = 11'd1;
            miss_code  = 32'h8000_0000;
            length_reg = 11'd2;
            expected_matches.delete();
            waiting = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got position %h matched %b",
                             $time, result.position, result.matched);
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (result.position !== want.position)
                    begin
                        $display("%0t: position expected %h, got %h",
                                 $time, want.position, result.position);
                        fail_count++;
                    end
                    if (result.matched !== want.matched)
                    begin
                        $display("%0t: matched expected %b, got %b",
                                 $time, want.matched, result.matched);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == cmkd_pkg::CFG_NO_MATCH)
                    miss_code = cfg_data;
                else if (cfg_index == cmkd_pkg::CFG_TABLE_LENGTH)
                    length_reg = cfg_data[10:0];
            end
            if (start && !busy)
            begin
                if (request.req_type == cmkd_pkg::REQ_WRITE)
                begin
                    entries[request.entry_index] = request.sample_value;
                    cursor = 11'd1;
                end
                else
                    predict_lookup(request.sample_value, request.tolerance);
            end
            waiting = expected_matches.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the closest-match core: stimulus, timeout and verdict
module tb;

    localparam int DEPTH       = 1024;
    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 2000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    cmkd_pkg::req_t    request = '0;
    logic              busy;
    logic              done;
    cmkd_pkg::result_t result;
    logic              cfg_we = 1'b0;
    logic              cfg_index = cmkd_pkg::CFG_NO_MATCH;
    logic [31:0]       cfg_data = '0;
    int                mismatches;
    int                pending;
    int                cycles = 0;
    int                items = 0;
    int                bulk = 0;
    int                calm_left = 0;
    logic [31:0]       loaded [DEPTH];
    bit                filled [DEPTH];

    closest_match_keep_duplicates_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    cmkd_match_monitor #(
        .DEPTH(DEPTH)
    ) u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(input cmkd_pkg::req_t r);
        int gap;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 18);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items++;
    endtask

    task automatic load_entry(input int unsigned idx, input logic [31:0] val);
        cmkd_pkg::req_t r;
        r.req_type     = cmkd_pkg::REQ_WRITE;
        r.entry_index  = idx[9:0];
        r.sample_value = val;
        r.tolerance    = $urandom;
        send_request(r);
        loaded[idx] = val;
        filled[idx] = 1'b1;
    endtask

    task automatic ask_nearest(input logic [31:0] val, input logic [31:0] tol);
        cmkd_pkg::req_t r;
        r.req_type     = cmkd_pkg::REQ_QUERY;
        r.entry_index  = 10'($urandom_range(0, DEPTH - 1));
        r.sample_value = val;
        r.tolerance    = tol;
        send_request(r);
    endtask

    // hold requests until every query has answered, then let a write settle
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        drain();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned raw;
        int unsigned eff;
        int unsigned n;
        int unsigned pick;
        int unsigned idx;
        int unsigned last_raw;
        int          phase;
        bit          fresh;
        bit          big_done;
        logic [31:0] v;
        logic [31:0] base;
        logic [31:0] vals [$];
        logic [31:0] qs [$];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, ties, clamped lengths, right match at the end, shrink below pointer
        load_entry(0, 32'h0);
        load_entry(1, 32'hFFFF_FFFF);
        ask_nearest(32'h0, 32'h0);
        ask_nearest(32'h7FFF_FFFF, 32'h0);
        ask_nearest(32'h8000_0000, 32'h7FFF_FFFF);
        ask_nearest(32'hFFFF_FFFF, 32'h0);
        load_entry(DEPTH - 1, 32'hA5A5_A5A5);
        load_entry(1, 32'd100);
        ask_nearest(32'd50, 32'hFFFF_FFFF);
        ask_nearest(32'd150, 32'd49);
        ask_nearest(32'd150, 32'd50);
        write_reg(cmkd_pkg::CFG_NO_MATCH, 32'h7FFF_FFFF);
        write_reg(cmkd_pkg::CFG_TABLE_LENGTH, 32'd0);
        ask_nearest(32'd1000, 32'd0);
        write_reg(cmkd_pkg::CFG_TABLE_LENGTH, 32'd1);
        ask_nearest(32'd0, 32'd0);
        load_entry(2, 32'd200);
        write_reg(cmkd_pkg::CFG_TABLE_LENGTH, 32'd3);
        ask_nearest(32'd1000, 32'd800);
        ask_nearest(32'd1000, 32'd800);
        write_reg(cmkd_pkg::CFG_TABLE_LENGTH, 32'd2);
        ask_nearest(32'd1000, 32'hFFFF_FFFF);

        phase    = 0;
        big_done = 1'b0;
        last_raw = 2;
        while (items - bulk < ITEM_TARGET)
        begin
            if (phase == 0 || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                write_reg(cmkd_pkg::CFG_NO_MATCH, v);
            end

            if (phase == 2)
                raw = $urandom_range(0, 1) ? 1024 : 2047;
            else
                case ($urandom_range(0, 9))
                    0: raw = $urandom_range(0, 1);
                    1: raw = $urandom_range(17, 64);
                    2: raw = big_done ? $urandom_range(65, 2047) : $urandom_range(2, 16);
                    default: raw = $urandom_range(2, 16);
                endcase
            eff = (raw < 2) ? 2 : ((raw > DEPTH) ? DEPTH : raw);
            if (raw != last_raw || $urandom_range(0, 2) == 0)
            begin
                v = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
                write_reg(cmkd_pkg::CFG_TABLE_LENGTH, {v[31:11], raw[10:0]});
                last_raw = raw;
            end

            fresh = 1'b0;
            for (int i = 0; i < eff; i++)
                if (!filled[i])
                    fresh = 1'b1;
            if (!fresh && eff <= 64 && $urandom_range(0, 9) < 6)
                fresh = 1'b1;

            if (fresh)
            begin
                vals.delete();
                pick = $urandom_range(0, 2);
                base = $urandom;
                for (int i = 0; i < eff; i++)
                    case (pick)
                        0: vals.push_back($urandom);
                        1: vals.push_back(base + $urandom_range(0, 15));
                        default: vals.push_back($urandom_range(0, 4095) << 12);
                    endcase
                vals.sort();
                if ($urandom_range(0, 1))
                    for (int i = 0; i < eff; i++)
                        load_entry(i, vals[i]);
                else
                    for (int i = eff - 1; i >= 0; i--)
                        load_entry(i, vals[i]);
                if (eff == DEPTH)
                begin
                    bulk += DEPTH;
                    big_done = 1'b1;
                end
            end

            n = $urandom_range(3, 24);
            qs.delete();
            for (int i = 0; i < n; i++)
            begin
                idx = $urandom_range(0, eff - 1);
                case ($urandom_range(0, 4))
                    0: v = $urandom;
                    1: v = loaded[idx];
                    2: v = loaded[idx] + $urandom_range(0, 64) - 32;
                    3: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    default: v = loaded[idx] + $urandom_range(0, 8191) - 4096;
                endcase
                qs.push_back(v);
            end
            // mostly a rising batch; now and then out of order
            if ($urandom_range(0, 6) != 0)
                qs.sort();

            foreach (qs[i])
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    idx = $urandom_range(0, 1) ? $urandom_range(0, eff - 1)
                                               : $urandom_range(0, DEPTH - 1);
                    v = (filled[idx] && $urandom_range(0, 1)) ? loaded[idx] : $urandom;
                    load_entry(idx, v);
                end
                if (i == n / 2 && (phase == 0 || $urandom_range(0, 4) == 0))
                    drain();
                case ($urandom_range(0, 5))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = $urandom_range(0, 64);
                    3: v = $urandom;
                    4: v = $urandom >> $urandom_range(0, 31);
                    default: v = $urandom_range(0, 4096);
                endcase
                ask_nearest(qs[i], v);
            end
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
